// ===== hw/rtl/stunp_pkg.sv =====
// ----------------------------------------------------------------------------
// stunp_pkg
// shared types, attribute codes and helpers of the stun message parser
// ----------------------------------------------------------------------------
`default_nettype none

package stunp_pkg;

  localparam int unsigned MaxMsgBytes  = 2048;
  localparam int unsigned HeaderBytes  = 20;
  localparam int unsigned CountW       = $clog2(MaxMsgBytes) + 1;
  localparam int unsigned QueueDepth   = 8;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueLevelW  = QueuePtrW + 1;

  localparam logic [15:0] TypeMappedAddr   = 16'h0001;
  localparam logic [15:0] TypeRespAddr     = 16'h0002;
  localparam logic [15:0] TypeChangeReq    = 16'h0003;
  localparam logic [15:0] TypeSourceAddr   = 16'h0004;
  localparam logic [15:0] TypeChangedAddr  = 16'h0005;
  localparam logic [15:0] TypeUsername     = 16'h0006;
  localparam logic [15:0] TypePassword     = 16'h0007;
  localparam logic [15:0] TypeIntegrity    = 16'h0008;
  localparam logic [15:0] TypeErrorCode    = 16'h0009;
  localparam logic [15:0] TypeUnknownAttr  = 16'h000A;
  localparam logic [15:0] TypeReflectedFrom = 16'h000B;
  localparam logic [15:0] TypeXorMapped    = 16'h0020;
  localparam logic [15:0] TypeXorOnly      = 16'h0021;
  localparam logic [15:0] TypeServerName   = 16'h0022;
  localparam logic [15:0] TypeSecondary    = 16'h0050;
  localparam logic [15:0] MandatoryMax     = 16'h7FFF;
  localparam logic [7:0]  FamilyIpv4       = 8'h01;

  localparam logic [1:0] CfgStringLimit  = 2'd0;
  localparam logic [1:0] CfgErrorLimit   = 2'd1;
  localparam logic [1:0] CfgUnknownLimit = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER, PH_AHDR, PH_VALUE, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    K_OTHER, K_ADDR, K_CHANGE, K_ERROR, K_ULIST, K_STRING, K_INTEG, K_XORONLY
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK, ST_SHORT_HDR, ST_MISMATCH, ST_OVERRUN,
    ST_BAD_LEN, ST_BAD_FAMILY, ST_UNK_MAND, ST_TOO_LARGE
  } status_t;

  typedef struct packed {
    logic [10:0] string_limit;
    logic [10:0] error_limit;
    logic [10:0] unknown_list_limit;
  } limits_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] attr_type;
    logic [10:0] attr_length;
    logic [15:0] port;
    logic [31:0] address;
    logic [31:0] value_word;
    logic [15:0] msg_type;
    logic [7:0]  id_first;
    status_t     status;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic kind_t kind_of(input logic [15:0] t);
    kind_t k;
    unique case (t)
      TypeMappedAddr, TypeRespAddr, TypeSourceAddr, TypeChangedAddr,
      TypeReflectedFrom, TypeXorMapped, TypeSecondary: k = K_ADDR;
      TypeChangeReq:   k = K_CHANGE;
      TypeErrorCode:   k = K_ERROR;
      TypeUnknownAttr: k = K_ULIST;
      TypeUsername, TypePassword, TypeServerName: k = K_STRING;
      TypeIntegrity:   k = K_INTEG;
      TypeXorOnly:     k = K_XORONLY;
      default:         k = K_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stunp_parser.sv =====
// ----------------------------------------------------------------------------
// stunp_parser
// per-byte header and attribute walker, emits up to two results per byte
// ----------------------------------------------------------------------------
`default_nettype none

module stunp_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_valid,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  stunp_pkg::limits_t     limits,
  output stunp_pkg::push_t       push
);

  localparam int unsigned CW = stunp_pkg::CountW;

  logic [CW-1:0]        byte_count_r, byte_count_nxt;
  logic [15:0]          header_type_r, header_type_nxt;
  logic [15:0]          header_length_r, header_length_nxt;
  logic [15:0]          bytes_left_r, bytes_left_nxt;
  stunp_pkg::phase_t    phase_r, phase_nxt;
  logic [15:0]          cur_type_r, cur_type_nxt;
  logic [15:0]          cur_length_r, cur_length_nxt;
  logic [15:0]          vidx_r, vidx_nxt;
  logic [15:0]          port_r, port_nxt;
  logic [31:0]          word_r, word_nxt;
  logic [7:0]           id_r, id_nxt;
  stunp_pkg::status_t   err_r, err_nxt;

  always_comb begin
    stunp_pkg::kind_t   k;
    logic [15:0]        len;
    logic [15:0]        bl_dec;
    logic [15:0]        vi_inc;
    logic               bad;
    logic               fin;
    logic               attr_v;
    stunp_pkg::result_t attr_res;
    stunp_pkg::result_t verd;
    stunp_pkg::status_t st;
    logic [16:0]        exp_cnt;

    byte_count_nxt    = byte_count_r;
    header_type_nxt   = header_type_r;
    header_length_nxt = header_length_r;
    bytes_left_nxt    = bytes_left_r;
    phase_nxt         = phase_r;
    cur_type_nxt      = cur_type_r;
    cur_length_nxt    = cur_length_r;
    vidx_nxt          = vidx_r;
    port_nxt          = port_r;
    word_nxt          = word_r;
    id_nxt            = id_r;
    err_nxt           = err_r;
    k      = stunp_pkg::kind_of(cur_type_r);
    len    = {cur_length_r[15:8], data_byte};
    bl_dec = bytes_left_r - 16'd1;
    vi_inc = vidx_r + 16'd1;
    bad    = 1'b0;
    fin    = 1'b0;
    attr_v = 1'b0;

    unique case (phase_r)
      stunp_pkg::PH_HEADER: begin
        if (byte_count_r == CW'(0)) header_type_nxt[15:8] = data_byte;
        if (byte_count_r == CW'(1)) header_type_nxt[7:0] = data_byte;
        if (byte_count_r == CW'(2)) header_length_nxt[15:8] = data_byte;
        if (byte_count_r == CW'(3)) header_length_nxt[7:0] = data_byte;
        if (byte_count_r == CW'(4)) id_nxt = data_byte;
        if (byte_count_r == CW'(stunp_pkg::HeaderBytes - 1)) begin
          bytes_left_nxt = header_length_r;
          vidx_nxt       = '0;
          phase_nxt      = (header_length_r != '0) ? stunp_pkg::PH_AHDR
                                                   : stunp_pkg::PH_DONE;
        end
      end
      stunp_pkg::PH_AHDR: begin
        bytes_left_nxt = bl_dec;
        case (vidx_r[1:0])
          2'd0: cur_type_nxt[15:8] = data_byte;
          2'd1: cur_type_nxt[7:0] = data_byte;
          2'd2: cur_length_nxt[15:8] = data_byte;
          default: cur_length_nxt[7:0] = data_byte;
        endcase
        if (vidx_r[1:0] != 2'd3) begin
          vidx_nxt = vi_inc;
          if (bl_dec == '0) begin
            err_nxt = stunp_pkg::ST_OVERRUN; phase_nxt = stunp_pkg::PH_ERROR;
          end
        end else begin
          vidx_nxt = '0;
          if (len > bl_dec) begin
            err_nxt = stunp_pkg::ST_OVERRUN; phase_nxt = stunp_pkg::PH_ERROR;
          end else begin
            case (k)
              stunp_pkg::K_ADDR:   bad = len != 16'd8;
              stunp_pkg::K_CHANGE: bad = len != 16'd4;
              stunp_pkg::K_ERROR:
                bad = len >= {5'd0, limits.error_limit} || len < 16'd4;
              stunp_pkg::K_ULIST:
                bad = len >= {5'd0, limits.unknown_list_limit} || len[1:0] != 2'd0;
              stunp_pkg::K_STRING:
                bad = len >= {5'd0, limits.string_limit} || len[1:0] != 2'd0;
              stunp_pkg::K_INTEG:  bad = len != 16'd20;
              default:             bad = 1'b0;
            endcase
            if (k == stunp_pkg::K_OTHER && cur_type_r <= stunp_pkg::MandatoryMax) begin
              err_nxt = stunp_pkg::ST_UNK_MAND; phase_nxt = stunp_pkg::PH_ERROR;
            end else if (bad) begin
              err_nxt = stunp_pkg::ST_BAD_LEN; phase_nxt = stunp_pkg::PH_ERROR;
            end else begin
              port_nxt = '0;
              word_nxt = '0;
              if (len == '0) fin = 1'b1;
              else phase_nxt = stunp_pkg::PH_VALUE;
            end
          end
        end
      end
      stunp_pkg::PH_VALUE: begin
        if (k == stunp_pkg::K_ADDR && vidx_r == 16'd1 && data_byte != stunp_pkg::FamilyIpv4)
        begin
          err_nxt = stunp_pkg::ST_BAD_FAMILY; phase_nxt = stunp_pkg::PH_ERROR;
        end else begin
          case (k)
            stunp_pkg::K_ADDR: begin
              if (vidx_r == 16'd2 || vidx_r == 16'd3) port_nxt = {port_r[7:0], data_byte};
              else if (vidx_r >= 16'd4) word_nxt = {word_r[23:0], data_byte};
            end
            stunp_pkg::K_CHANGE: word_nxt = {word_r[23:0], data_byte};
            stunp_pkg::K_ERROR: begin
              if (vidx_r == 16'd2) word_nxt = word_r | {16'd0, data_byte, 8'd0};
              else if (vidx_r == 16'd3) word_nxt = word_r | {24'd0, data_byte};
            end
            default: ;
          endcase
          bytes_left_nxt = bl_dec;
          vidx_nxt       = vi_inc;
          if (vi_inc == cur_length_r) fin = 1'b1;
        end
      end
      default: ;
    endcase

    // finish of an accepted attribute
    attr_res             = '0;
    attr_res.attr_type   = cur_type_nxt;
    attr_res.attr_length = cur_length_nxt[10:0];
    if (fin) begin
      attr_v   = (k != stunp_pkg::K_OTHER) || (cur_type_nxt <= stunp_pkg::MandatoryMax);
      vidx_nxt = '0;
      phase_nxt = (bytes_left_nxt != '0) ? stunp_pkg::PH_AHDR : stunp_pkg::PH_DONE;
      if (stunp_pkg::kind_of(cur_type_nxt) == stunp_pkg::K_ADDR) begin
        attr_res.port    = port_nxt;
        attr_res.address = word_nxt;
      end else if (stunp_pkg::kind_of(cur_type_nxt) == stunp_pkg::K_CHANGE ||
                   stunp_pkg::kind_of(cur_type_nxt) == stunp_pkg::K_ERROR) begin
        attr_res.value_word = word_nxt;
      end
    end
    attr_res.msg_type = header_type_nxt;
    attr_res.id_first = id_nxt;

    if (byte_count_r < CW'(stunp_pkg::MaxMsgBytes)) byte_count_nxt = byte_count_r + CW'(1);

    // end-of-message verdict
    exp_cnt = {1'b0, header_length_nxt} + 17'(stunp_pkg::HeaderBytes);
    if (byte_count_nxt >= CW'(stunp_pkg::MaxMsgBytes - 1)) st = stunp_pkg::ST_TOO_LARGE;
    else if (byte_count_nxt < CW'(stunp_pkg::HeaderBytes)) st = stunp_pkg::ST_SHORT_HDR;
    else if (17'(byte_count_nxt) != exp_cnt) st = stunp_pkg::ST_MISMATCH;
    else st = err_nxt;
    verd             = '0;
    verd.result_kind = 1'b1;
    verd.msg_type    = header_type_nxt;
    verd.id_first    = id_nxt;
    verd.status      = st;
    verd.last_result = 1'b1;

    push = '0;
    if (byte_valid) begin
      push.count = {1'b0, attr_v} + {1'b0, last_byte};
      push.first  = attr_v ? attr_res : verd;
      push.second = verd;
    end

    if (last_byte) begin
      byte_count_nxt = '0; header_type_nxt = '0; header_length_nxt = '0;
      bytes_left_nxt = '0; phase_nxt = stunp_pkg::PH_HEADER; cur_type_nxt = '0;
      cur_length_nxt = '0; vidx_nxt = '0; port_nxt = '0; word_nxt = '0;
      id_nxt = '0; err_nxt = stunp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0; header_type_r <= '0; header_length_r <= '0;
      bytes_left_r <= '0; phase_r <= stunp_pkg::PH_HEADER; cur_type_r <= '0;
      cur_length_r <= '0; vidx_r <= '0; port_r <= '0; word_r <= '0;
      id_r <= '0; err_r <= stunp_pkg::ST_OK;
    end else if (byte_valid) begin
      byte_count_r <= byte_count_nxt; header_type_r <= header_type_nxt;
      header_length_r <= header_length_nxt; bytes_left_r <= bytes_left_nxt;
      phase_r <= phase_nxt; cur_type_r <= cur_type_nxt;
      cur_length_r <= cur_length_nxt; vidx_r <= vidx_nxt; port_r <= port_nxt;
      word_r <= word_nxt; id_r <= id_nxt; err_r <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stunp_queue.sv =====
// ----------------------------------------------------------------------------
// stunp_queue
// result queue, two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stunp_queue (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  stunp_pkg::push_t                         push,
  input  wire logic                                pop,
  output stunp_pkg::result_t                       head,
  output logic                                     not_empty,
  output logic [stunp_pkg::QueueLevelW-1:0]        level
);

  localparam int unsigned PW = stunp_pkg::QueuePtrW;
  localparam int unsigned LW = stunp_pkg::QueueLevelW;

  stunp_pkg::result_t mem_r [stunp_pkg::QueueDepth];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          do_pop;

  assign do_pop    = pop && (level_r != '0);
  assign head      = mem_r[rp_r];
  assign not_empty = level_r != '0;
  assign level     = level_r;

  always_comb begin
    wp_nxt    = wp_r + PW'(push.count);
    rp_nxt    = rp_r + PW'(do_pop);
    level_nxt = level_r + LW'(push.count) - LW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wp_r] <= push.first;
    if (push.count == 2'd2) mem_r[wp_r + PW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; level_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; level_r <= level_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stun_message_parser.sv =====
// ----------------------------------------------------------------------------
// stun_message_parser
// byte-serial stun message parser with attribute and verdict results
// ----------------------------------------------------------------------------
// Takes a stun message one byte per word with tlast on the final byte and
// accepts one byte per ready cycle. Each byte is registered, then decoded
// combinationally into the header and attribute state; a finished
// attribute and the end-of-message verdict (attribute first) go into an
// eight-word result queue that drains one word per cycle while out_tready
// is high. in_tready drops only while the queue and the byte in flight
// could need more than the free slots, i.e. when the result side stalls.
// The user must write limits through cfg_ while the block is idle (unchecked).
`default_nettype none

module stun_message_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,    // data_byte
  input  wire logic         in_tlast,    // last_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // attr_type, attr_length, port, address, value_word, msg_type, id_first,
  // status, two zero pad bits
  output logic [135:0]      out_tdata,
  output logic              out_tuser,   // result_kind
  output logic              out_tlast,   // last_result
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [10:0]  cfg_wdata
);

  localparam int unsigned LW = stunp_pkg::QueueLevelW;

  stunp_pkg::limits_t  limits_r;
  logic                stg_v_r;
  logic [7:0]          stg_byte_r;
  logic                stg_last_r;
  stunp_pkg::push_t    push;
  stunp_pkg::result_t  head;
  logic                not_empty;
  logic [LW-1:0]       level;
  logic [LW:0]         pending;
  logic                in_acc;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.string_limit       <= 11'd256;
      limits_r.error_limit        <= 11'd260;
      limits_r.unknown_list_limit <= 11'd18;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stunp_pkg::CfgStringLimit:  limits_r.string_limit       <= cfg_wdata;
        stunp_pkg::CfgErrorLimit:   limits_r.error_limit        <= cfg_wdata;
        stunp_pkg::CfgUnknownLimit: limits_r.unknown_list_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // room for two results of the byte in flight and two of the new one
  assign pending   = {1'b0, level} + {{(LW-1){1'b0}}, stg_v_r, 1'b0};
  assign in_tready = pending <= (LW+1)'(stunp_pkg::QueueDepth - 2);
  assign in_acc    = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) stg_v_r <= 1'b0;
    else        stg_v_r <= in_acc;
  end
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  stunp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (stg_v_r),
    .data_byte  (stg_byte_r),
    .last_byte  (stg_last_r),
    .limits     (limits_r),
    .push       (push)
  );

  stunp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tready),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  assign out_tvalid = not_empty;
  assign out_tuser  = head.result_kind;
  assign out_tlast  = head.last_result;
  assign out_tdata  = {2'b00, head.status, head.id_first, head.msg_type,
                       head.value_word, head.address, head.port,
                       head.attr_length, head.attr_type};

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LW'(stunp_pkg::QueueDepth))
    else $error("result queue overfilled");

  // a verdict always closes the message
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("verdict without last mark");

  // attribute words carry no status and never end the message
  a_attr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tlast && out_tdata[133:131] == 3'd0)
    else $error("attribute word with status or last mark");

  // results come only from a byte in flight
  a_push_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_v_r |-> push.count == 2'd0)
    else $error("result pushed with no byte in flight");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stun message parser
// ----------------------------------------------------------------------------
// Feeds stun messages byte by byte, predicts every attribute and verdict word
// in a behavioral parser, and compares each accepted result word whole to
// its prediction. A directed table opens the run, then random messages follow,
// mostly well formed with random attributes, some broken or pure noise. Both
// sides idle at random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  stun_message_parser i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---- predictor state, a private copy of the parser -----------------------
  logic [10:0] lim_string, lim_error, lim_ulist;
  logic [11:0] p_count;
  logic [15:0] p_mtype, p_mlen, p_left, p_ctype, p_clen, p_idx;
  logic [15:0] p_port;
  logic [31:0] p_word;
  logic [7:0]  p_id;
  stunp_pkg::phase_t  p_phase;
  stunp_pkg::status_t p_err;

  stunp_pkg::result_t expected_words[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit idle_free = 1'b0;   // stretch with no idling on either side
  bit hold_off = 1'b0;    // long receiver stall

  function automatic stunp_pkg::kind_t attr_kind(input logic [15:0] t);
    case (t)
      stunp_pkg::TypeMappedAddr, stunp_pkg::TypeRespAddr, stunp_pkg::TypeSourceAddr,
      stunp_pkg::TypeChangedAddr, stunp_pkg::TypeReflectedFrom, stunp_pkg::TypeXorMapped,
      stunp_pkg::TypeSecondary: return stunp_pkg::K_ADDR;
      stunp_pkg::TypeChangeReq:   return stunp_pkg::K_CHANGE;
      stunp_pkg::TypeErrorCode:   return stunp_pkg::K_ERROR;
      stunp_pkg::TypeUnknownAttr: return stunp_pkg::K_ULIST;
      stunp_pkg::TypeUsername, stunp_pkg::TypePassword,
      stunp_pkg::TypeServerName:  return stunp_pkg::K_STRING;
      stunp_pkg::TypeIntegrity:   return stunp_pkg::K_INTEG;
      stunp_pkg::TypeXorOnly:     return stunp_pkg::K_XORONLY;
      default:                    return stunp_pkg::K_OTHER;
    endcase
  endfunction

  task automatic clear_msg();
    p_count = '0; p_mtype = '0; p_mlen = '0; p_left = '0;
    p_phase = stunp_pkg::PH_HEADER;
    p_ctype = '0; p_clen = '0; p_idx = '0; p_port = '0; p_word = '0;
    p_id = '0; p_err = stunp_pkg::ST_OK;
  endtask

  task automatic fail_msg(input stunp_pkg::status_t s);
    p_err = s;
    p_phase = stunp_pkg::PH_ERROR;
  endtask

  // push the result of a finished attribute, unknown optional ones give none
  task automatic close_attr();
    stunp_pkg::result_t r;
    stunp_pkg::kind_t k;
    k = attr_kind(p_ctype);
    if (k != stunp_pkg::K_OTHER || p_ctype <= stunp_pkg::MandatoryMax) begin
      r = '0;
      r.attr_type = p_ctype;
      r.attr_length = p_clen[10:0];
      if (k == stunp_pkg::K_ADDR) begin
        r.port = p_port;
        r.address = p_word;
      end else if (k == stunp_pkg::K_CHANGE || k == stunp_pkg::K_ERROR) begin
        r.value_word = p_word;
      end
      r.msg_type = p_mtype;
      r.id_first = p_id;
      r.status = stunp_pkg::ST_OK;
      expected_words.push_back(r);
    end
    p_idx = '0;
    p_phase = (p_left != 0) ? stunp_pkg::PH_AHDR : stunp_pkg::PH_DONE;
  endtask

  task automatic judge_attr();
    stunp_pkg::kind_t k;
    logic bad;
    k = attr_kind(p_ctype);
    bad = 1'b0;
    case (k)
      stunp_pkg::K_ADDR:   bad = p_clen != 8;
      stunp_pkg::K_CHANGE: bad = p_clen != 4;
      stunp_pkg::K_ERROR:  bad = p_clen >= lim_error || p_clen < 4;
      stunp_pkg::K_ULIST:  bad = p_clen >= lim_ulist || p_clen[1:0] != 0;
      stunp_pkg::K_STRING: bad = p_clen >= lim_string || p_clen[1:0] != 0;
      stunp_pkg::K_INTEG:  bad = p_clen != 20;
      stunp_pkg::K_XORONLY: bad = 1'b0;
      default: begin
        if (p_ctype <= stunp_pkg::MandatoryMax) begin
          fail_msg(stunp_pkg::ST_UNK_MAND);
          return;
        end
      end
    endcase
    if (bad) begin
      fail_msg(stunp_pkg::ST_BAD_LEN);
      return;
    end
    p_port = '0; p_word = '0; p_idx = '0;
    if (p_clen == 0) close_attr();
    else p_phase = stunp_pkg::PH_VALUE;
  endtask

  // advance the predictor by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    stunp_pkg::result_t r;
    stunp_pkg::kind_t k;
    case (p_phase)
      stunp_pkg::PH_HEADER: begin
        case (p_count)
          0: p_mtype[15:8] = b;
          1: p_mtype[7:0] = b;
          2: p_mlen[15:8] = b;
          3: p_mlen[7:0] = b;
          4: p_id = b;
          default: ;
        endcase
        if (p_count == stunp_pkg::HeaderBytes - 1) begin
          p_left = p_mlen;
          p_idx = '0;
          p_phase = (p_left != 0) ? stunp_pkg::PH_AHDR : stunp_pkg::PH_DONE;
        end
      end
      stunp_pkg::PH_AHDR: begin
        case (p_idx)
          0: p_ctype[15:8] = b;
          1: p_ctype[7:0] = b;
          2: p_clen[15:8] = b;
          default: p_clen[7:0] = b;
        endcase
        p_left = p_left - 1;
        if (p_idx < 3) begin
          p_idx = p_idx + 1;
          if (p_left == 0) fail_msg(stunp_pkg::ST_OVERRUN);
        end else begin
          p_idx = '0;
          if (p_clen > p_left) fail_msg(stunp_pkg::ST_OVERRUN);
          else judge_attr();
        end
      end
      stunp_pkg::PH_VALUE: begin
        k = attr_kind(p_ctype);
        if (k == stunp_pkg::K_ADDR) begin
          if (p_idx == 1) begin
            if (b != stunp_pkg::FamilyIpv4) fail_msg(stunp_pkg::ST_BAD_FAMILY);
          end else if (p_idx == 2 || p_idx == 3) begin
            p_port = {p_port[7:0], b};
          end else if (p_idx >= 4) begin
            p_word = {p_word[23:0], b};
          end
        end else if (k == stunp_pkg::K_CHANGE) begin
          p_word = {p_word[23:0], b};
        end else if (k == stunp_pkg::K_ERROR) begin
          if (p_idx == 2) p_word[15:8] = p_word[15:8] | b;
          else if (p_idx == 3) p_word[7:0] = p_word[7:0] | b;
        end
        if (p_phase == stunp_pkg::PH_VALUE) begin
          p_left = p_left - 1;
          p_idx = p_idx + 1;
          if (p_idx == p_clen) close_attr();
        end
      end
      default: ;
    endcase
    if (p_count < stunp_pkg::MaxMsgBytes) p_count = p_count + 1;
    if (lst) begin
      r = '0;
      r.result_kind = 1'b1;
      r.msg_type = p_mtype;
      r.id_first = p_id;
      r.last_result = 1'b1;
      if (p_count >= stunp_pkg::MaxMsgBytes - 1) r.status = stunp_pkg::ST_TOO_LARGE;
      else if (p_count < stunp_pkg::HeaderBytes) r.status = stunp_pkg::ST_SHORT_HDR;
      else if ({4'd0, p_count} != p_mlen + stunp_pkg::HeaderBytes)
        r.status = stunp_pkg::ST_MISMATCH;
      else r.status = p_err;
      expected_words.push_back(r);
      clear_msg();
    end
  endtask

  // ---- driving -------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!idle_free && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, lst);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [10:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      stunp_pkg::CfgStringLimit: lim_string = v;
      stunp_pkg::CfgErrorLimit:  lim_error = v;
      default:                   lim_ulist = v;
    endcase
  endtask

  // wait until every expected word is out
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---- message builder -----------------------------------------------------
  logic [7:0] msg[$];

  task automatic put16(input logic [15:0] v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endtask

  task automatic start_msg(input logic [15:0] mtype);
    msg.delete();
    put16(mtype);
    put16(16'd0);
    repeat (16) msg.push_back(8'($urandom));
  endtask

  // patch the header length to the body built so far
  task automatic seal_len();
    logic [15:0] n;
    n = 16'(msg.size() - stunp_pkg::HeaderBytes);
    msg[2] = n[15:8];
    msg[3] = n[7:0];
  endtask

  // bytes of one message in order; the sender may idle before any byte unless idle_free is set
  task automatic send_msg();
    @(negedge clk);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    in_tvalid <= 1'b0;
  endtask

  task automatic add_attr(input logic [15:0] t, input int len);
    stunp_pkg::kind_t k;
    k = attr_kind(t);
    put16(t);
    put16(16'(len));
    for (int i = 0; i < len; i++) begin
      if (k == stunp_pkg::K_ADDR && i == 1 && $urandom_range(15) != 0)
        msg.push_back(stunp_pkg::FamilyIpv4);
      else msg.push_back(8'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_type();
    logic [15:0] list[16];
    list = '{stunp_pkg::TypeMappedAddr, stunp_pkg::TypeRespAddr,
             stunp_pkg::TypeChangeReq, stunp_pkg::TypeSourceAddr,
             stunp_pkg::TypeChangedAddr, stunp_pkg::TypeUsername,
             stunp_pkg::TypePassword, stunp_pkg::TypeIntegrity,
             stunp_pkg::TypeErrorCode, stunp_pkg::TypeUnknownAttr,
             stunp_pkg::TypeReflectedFrom, stunp_pkg::TypeXorMapped,
             stunp_pkg::TypeXorOnly, stunp_pkg::TypeServerName,
             stunp_pkg::TypeSecondary, 16'h8000};
    if ($urandom_range(19) == 0) return 16'($urandom);
    if ($urandom_range(9) == 0) return 16'h8000 | 16'($urandom);
    return list[$urandom_range(15)];
  endfunction

  function automatic int legal_len(input logic [15:0] t);
    case (attr_kind(t))
      stunp_pkg::K_ADDR:   return 8;
      stunp_pkg::K_CHANGE: return 4;
      stunp_pkg::K_ERROR:  return 4 + $urandom_range(8);
      stunp_pkg::K_ULIST:  return 4 * $urandom_range(4);
      stunp_pkg::K_STRING: return 4 * $urandom_range(6);
      stunp_pkg::K_INTEG:  return 20;
      default:             return $urandom_range(10);
    endcase
  endfunction

  // ---- directed table ------------------------------------------------------
  typedef struct {
    logic [15:0]        atype;   // attribute type, 0 for header only
    int                 alen;    // declared value length
    int                 adj;     // bytes added to (or cut from) the real body
    bit                 typed;   // verdict status typed in
    stunp_pkg::status_t vstat;
  } row_t;

  row_t rows[$];

  task automatic run_row(input row_t rw);
    stunp_pkg::status_t saved;
    start_msg(16'h0101);
    if (rw.atype != 0 || rw.alen != 0) add_attr(rw.atype, rw.alen);
    seal_len();
    if (rw.adj > 0) repeat (rw.adj) msg.push_back(8'hFF);
    else if (rw.adj < 0) repeat (-rw.adj) void'(msg.pop_back());
    send_msg();
    if (rw.typed && expected_words.size() != 0) begin
      saved = expected_words[$].status;
      if (saved != rw.vstat) begin
        $display("%0t: table verdict expected %0d predicted %0d",
                 $time, rw.vstat, saved);
        errors++;
      end
    end
  endtask

  // ---- receiver ------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (idle_free) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 22);
  end

  // result word check, sampled at the rising edge
  always @(posedge clk) begin
    stunp_pkg::result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[15:0], out_tdata[26:16], out_tdata[42:27],
             out_tdata[74:43], out_tdata[106:75], out_tdata[122:107],
             out_tdata[130:123], out_tdata[133:131], out_tlast};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: word mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // long receiver hold-off counted in its own process
  initial begin
    wait (stall_left > 0);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (stall_left) @(negedge clk);
    hold_off = 1'b0;
  end

  // ---- main sequence -------------------------------------------------------
  initial begin
    int n_bytes;
    int nattr;
    logic [15:0] t;
    lim_string = 11'd256; lim_error = 11'd260; lim_ulist = 11'd18;
    clear_msg();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows = '{
      '{16'h0000, 0, 0, 1'b1, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeMappedAddr, 8, 0, 1'b0, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeChangeReq, 4, 0, 1'b0, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeErrorCode, 4, 0, 1'b0, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeErrorCode, 2, 0, 1'b1, stunp_pkg::ST_BAD_LEN},
      '{stunp_pkg::TypeUnknownAttr, 16, 0, 1'b0, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeUnknownAttr, 6, 0, 1'b1, stunp_pkg::ST_BAD_LEN},
      '{stunp_pkg::TypeUsername, 0, 0, 1'b0, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeIntegrity, 20, 0, 1'b0, stunp_pkg::ST_OK},
      '{stunp_pkg::TypeIntegrity, 4, 0, 1'b1, stunp_pkg::ST_BAD_LEN},
      '{stunp_pkg::TypeXorOnly, 3, 0, 1'b0, stunp_pkg::ST_OK},
      '{16'hFFFF, 5, 0, 1'b0, stunp_pkg::ST_OK},
      '{16'h7FFF, 0, 0, 1'b1, stunp_pkg::ST_UNK_MAND},
      '{stunp_pkg::TypeSecondary, 8, 2, 1'b1, stunp_pkg::ST_MISMATCH},
      '{stunp_pkg::TypeChangeReq, 4, -2, 1'b1, stunp_pkg::ST_MISMATCH},
      '{16'h0000, 0, -10, 1'b1, stunp_pkg::ST_SHORT_HDR},
      '{stunp_pkg::TypeChangeReq, 4, -10, 1'b1, stunp_pkg::ST_SHORT_HDR}
    };
    foreach (rows[i]) run_row(rows[i]);

    // attribute overrun: declared length beyond the body
    start_msg(16'h0111); add_attr(stunp_pkg::TypeUsername, 8); seal_len();
    msg[23] = 8'd40; send_msg();
    // attribute header cut short inside the body
    start_msg(16'h0111); put16(stunp_pkg::TypeChangeReq); seal_len(); send_msg();
    // bad family
    start_msg(16'h0101); add_attr(stunp_pkg::TypeMappedAddr, 8); msg[25] = 8'h02;
    seal_len(); send_msg();
    // too large, all 0xFF bytes
    msg.delete();
    repeat (2047) msg.push_back(8'hFF);
    send_msg();
    drain();

    // walk the limits through extremes and mid values
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_limit(stunp_pkg::CfgStringLimit, 11'd4);
          write_limit(stunp_pkg::CfgErrorLimit, 11'd4);
          write_limit(stunp_pkg::CfgUnknownLimit, 11'd4);
        end
        1: begin
          write_limit(stunp_pkg::CfgStringLimit, 11'd2047);
          write_limit(stunp_pkg::CfgErrorLimit, 11'd2047);
          write_limit(stunp_pkg::CfgUnknownLimit, 11'd2047);
        end
        2: begin
          write_limit(stunp_pkg::CfgStringLimit, 11'($urandom_range(4, 40)));
          write_limit(stunp_pkg::CfgErrorLimit, 11'($urandom_range(4, 20)));
          write_limit(stunp_pkg::CfgUnknownLimit, 11'($urandom_range(4, 20)));
        end
        default: begin
          write_limit(stunp_pkg::CfgStringLimit, 11'd256);
          write_limit(stunp_pkg::CfgErrorLimit, 11'd260);
          write_limit(stunp_pkg::CfgUnknownLimit, 11'd18);
        end
      endcase
      if (ph == 1) stall_left = 400;
      idle_free = (ph == 2);
      n_bytes = 0;
      while (n_bytes < 400) begin
        start_msg(16'($urandom));
        case ($urandom_range(9))
          0: begin
            // noise of random length and content
            msg.delete();
            repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom));
          end
          1: begin
            // broken: random attribute lengths
            repeat ($urandom_range(1, 3)) add_attr(pick_type(), $urandom_range(24));
            seal_len();
            if ($urandom_range(1)) msg[2 + $urandom_range(1)] = 8'($urandom);
          end
          default: begin
            nattr = $urandom_range(1, 5);
            repeat (nattr) begin
              t = pick_type();
              add_attr(t, legal_len(t));
            end
            seal_len();
          end
        endcase
        n_bytes += msg.size();
        send_msg();
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // ---- end of run ----------------------------------------------------------
  initial begin
    wait (stim_done);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_words.size() != 0)
        $display("%0t: %0d words never came", $time, expected_words.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
